// ----- rtl/core/bfc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register indexes and helpers for the box frustum cull block.
// Depends on nothing; every other file of the block imports it.
package bfc_pkg;

	localparam int NUM_PLANES = 6;

	localparam logic [2:0] CFG_PLANE_FRONT  = 3'd0;
	localparam logic [2:0] CFG_PLANE_BACK   = 3'd1;
	localparam logic [2:0] CFG_PLANE_LEFT   = 3'd2;
	localparam logic [2:0] CFG_PLANE_RIGHT  = 3'd3;
	localparam logic [2:0] CFG_PLANE_TOP    = 3'd4;
	localparam logic [2:0] CFG_PLANE_BOTTOM = 3'd5;
	localparam logic [2:0] CFG_TOLERANCE    = 3'd6;

	localparam logic [2:0]  NO_PLANE  = 3'd6;
	localparam logic [15:0] TOL_RESET = 16'd66;

	typedef struct packed {
		logic signed [15:0] corner_x;
		logic signed [15:0] corner_y;
		logic signed [15:0] corner_z;
		logic               last_corner;
	} corner_t;

	typedef struct packed {
		logic       visible;
		logic [2:0] rejecting_plane;
	} verdict_t;

	// Field order puts nx in the low bits of the 64-bit register.
	typedef struct packed {
		logic signed [15:0] d;
		logic signed [15:0] nz;
		logic signed [15:0] ny;
		logic signed [15:0] nx;
	} plane_t;

	typedef struct packed {
		logic [NUM_PLANES-1:0] hits;
		logic                  last;
	} test_t;

	function automatic logic [2:0] first_clear(input logic [NUM_PLANES-1:0] mask);
		logic [2:0] idx;
		idx = NO_PLANE;
		for (int p = NUM_PLANES - 1; p >= 0; p--) begin
			if (!mask[p]) begin
				idx = 3'(p);
			end
		end
		return idx;
	endfunction

endpackage

// ----- rtl/core/bfc_front.sv -----
`timescale 1ns / 1ps
// Front part: accepts corners and tests each against all six planes in a
// two-stage pipeline. Depends on bfc_pkg.
module bfc_front #(
	parameter int COORD_WIDTH = 16,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  bfc_pkg::corner_t                in_data,
	input  bfc_pkg::plane_t                 planes [bfc_pkg::NUM_PLANES],
	input  logic [15:0]                     tolerance,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level,
	output logic                            push,
	output bfc_pkg::test_t                  push_data
);
	import bfc_pkg::*;

	localparam int LW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = 16 + COORD_WIDTH;
	localparam int SW = PW + 3;

	logic signed [COORD_WIDTH-1:0] cx, cy, cz;
	logic                          accept;

	logic                          valid_s1;
	logic                          last_s1;
	logic signed [PW-1:0]          px_s1 [NUM_PLANES];
	logic signed [PW-1:0]          py_s1 [NUM_PLANES];
	logic signed [PW-1:0]          pz_s1 [NUM_PLANES];
	logic signed [15:0]            d_s1  [NUM_PLANES];

	logic signed [SW-1:0]          sum   [NUM_PLANES];
	logic [NUM_PLANES-1:0]         hits;

	logic                          valid_s2;
	test_t                         test_s2;

	assign cx = COORD_WIDTH'($unsigned(in_data.corner_x));
	assign cy = COORD_WIDTH'($unsigned(in_data.corner_y));
	assign cz = COORD_WIDTH'($unsigned(in_data.corner_z));

	// Every request in flight holds a queue slot, so the pipeline never stalls.
	assign in_ready = ({1'b0, q_level} + (LW+1)'(valid_s1) + (LW+1)'(valid_s2))
		< (LW+1)'(QUEUE_DEPTH);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= in_data.last_corner;
			for (int p = 0; p < NUM_PLANES; p++) begin
				px_s1[p] <= PW'(planes[p].nx * cx);
				py_s1[p] <= PW'(planes[p].ny * cy);
				pz_s1[p] <= PW'(planes[p].nz * cz);
				d_s1[p]  <= planes[p].d;
			end
		end
	end

	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			sum[p] = SW'(px_s1[p]) + SW'(py_s1[p]) + SW'(pz_s1[p])
				+ (SW'(d_s1[p]) <<< 8) + SW'($signed({1'b0, tolerance}));
			hits[p] = !sum[p][SW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			test_s2.hits <= hits;
			test_s2.last <= last_s1;
		end
	end

	assign push      = valid_s2;
	assign push_data = test_s2;

endmodule

// ----- rtl/core/bfc_queue.sv -----
`timescale 1ns / 1ps
// Short register queue of plane test results between the front and back parts.
// Depends on bfc_pkg.
module bfc_queue #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  bfc_pkg::test_t                   push_data,
	input  logic                             pop,
	output logic                             head_valid,
	output bfc_pkg::test_t                   head_data,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] level
);
	import bfc_pkg::*;

	localparam int LW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	test_t          entry_q [QUEUE_DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [LW-1:0]  level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			level_q <= level_q + LW'(push) - LW'(pop);
		end
	end

	assign head_valid = (level_q != '0);
	assign head_data  = entry_q[rd_ptr_q];
	assign level      = level_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level_q < LW'(QUEUE_DEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(QUEUE_DEPTH))
		else $error("queue level beyond depth");

endmodule

// ----- rtl/core/bfc_back.sv -----
`timescale 1ns / 1ps
// Back part: folds plane test results into the box mask and issues the verdict
// on the last corner through an output register. Depends on bfc_pkg.
module bfc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  bfc_pkg::test_t    head_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output bfc_pkg::verdict_t out_data
);
	import bfc_pkg::*;

	logic [NUM_PLANES-1:0] mask_q;
	logic [NUM_PLANES-1:0] merged;
	logic [2:0]            reject;
	logic                  out_valid_q;
	verdict_t              out_data_q;

	// Corners that end no box drain freely; the last one waits for a free output.
	assign pop    = head_valid && (!head_data.last || !out_valid_q || out_ready);
	assign merged = mask_q | head_data.hits;
	assign reject = first_clear(merged);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= head_data.last ? '0 : merged;
			end
			if (pop && head_data.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_data.last) begin
			out_data_q.visible         <= (reject == NO_PLANE);
			out_data_q.rejecting_plane <= reject;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_mask_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_data.last) |=> (mask_q == '0))
		else $error("mask not cleared after last corner");

	a_verdict_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.visible == (out_data_q.rejecting_plane == NO_PLANE)))
		else $error("visible flag disagrees with rejecting plane");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && head_valid && head_data.last) |-> !pop)
		else $error("verdict overwritten while waiting");

endmodule

// ----- rtl/core/box_frustum_cull.sv -----
`timescale 1ns / 1ps
// Top level of the box frustum cull block: configuration registers, front,
// queue and back parts. Depends on bfc_pkg, bfc_front, bfc_queue and bfc_back.
//
// The block takes one box corner per clock cycle while input ready is high, and tests
// it against six planes at once in a two-stage multiply and add pipeline. The verdict
// for a box is presented once its last corner has passed the pipeline, the queue and
// the output register, when the output is free. A queue of QUEUE_DEPTH test results
// separates the plane pipeline from the mask and output logic; input ready drops only
// when that queue, counting corners still in the pipeline, is full, which happens
// only while verdicts are held back at the output. Configuration writes are always
// taken and must be made while the block is idle.
module box_frustum_cull #(
	parameter int COORD_WIDTH = 16,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bfc_pkg::corner_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output bfc_pkg::verdict_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);
	import bfc_pkg::*;

	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	plane_t        planes_q [NUM_PLANES];
	logic [15:0]   tolerance_q;

	logic          push;
	test_t         push_data;
	logic          pop;
	logic          head_valid;
	test_t         head_data;
	logic [LW-1:0] q_level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				planes_q[p] <= '0;
			end
			tolerance_q <= TOL_RESET;
		end else if (cfg_valid) begin
			if (cfg_index inside {[CFG_PLANE_FRONT:CFG_PLANE_BOTTOM]}) begin
				planes_q[cfg_index] <= cfg_data;
			end else if (cfg_index == CFG_TOLERANCE) begin
				tolerance_q <= cfg_data[15:0];
			end
		end
	end

	bfc_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.planes    (planes_q),
		.tolerance (tolerance_q),
		.q_level   (q_level),
		.push      (push),
		.push_data (push_data)
	);

	bfc_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data),
		.level      (q_level)
	);

	bfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
